/* rtl/core/mlpl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlpl_pkg
// Shared constants and controller command type for the MAC learning lookup.
// ----------------------------------------------------------------------------
package mlpl_pkg;

    localparam int unsigned DEF_ENTRIES   = 16;
    localparam int unsigned DEF_ADDR_BITS = 48;

    // port masks and the miss mask register are fixed at 8 bits
    localparam int unsigned PORT_BITS = 8;
    localparam logic [PORT_BITS-1:0] MISS_MASK_RESET = 8'h55;

    // apb register map
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam logic [0:0]  REG_MISS_PORT_MASK = 1'b0;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture the accepted item
        logic clear_ptr;  // reset the replacement pointer
        logic match;      // register the match vectors
        logic commit;     // resolve lookup, learn, load result
    } dp_cmd_t;

endpackage : mlpl_pkg
`default_nettype wire

/* rtl/core/mlpl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlpl_ctrl
// Sequencer for one lookup: capture, match, commit, with a result register
// handshake on the output side.
// ----------------------------------------------------------------------------
module mlpl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_lookup_request,
    input  wire logic              s_clear_pointer,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mlpl_pkg::dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    // result slot is free if empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.load      = accept;
        cmd.clear_ptr = accept && s_clear_pointer;
        cmd.match     = (state_reg == ST_MATCH);
        cmd.commit    = (state_reg == ST_COMMIT) && out_free;

        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_lookup_request) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule : mlpl_ctrl
`default_nettype wire

/* rtl/core/mlpl_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlpl_dp
// Table registers, parallel address compare, priority select, learning and
// round-robin replacement, and the result register.
// ----------------------------------------------------------------------------
module mlpl_dp #(
    parameter int unsigned ENTRIES   = mlpl_pkg::DEF_ENTRIES,
    parameter int unsigned ADDR_BITS = mlpl_pkg::DEF_ADDR_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire mlpl_pkg::dp_cmd_t              cmd,
    input  wire logic [ADDR_BITS-1:0]           s_dest_address,
    input  wire logic [ADDR_BITS-1:0]           s_source_address,
    input  wire logic [mlpl_pkg::PORT_BITS-1:0] s_source_port_mask,
    input  wire logic [mlpl_pkg::PORT_BITS-1:0] miss_port_mask,
    output logic [mlpl_pkg::PORT_BITS-1:0]      m_out_port_mask,
    output logic                                m_hit
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [ADDR_BITS-1:0]           addr_reg  [ENTRIES];
    logic [mlpl_pkg::PORT_BITS-1:0] pmask_reg [ENTRIES];
    logic [IDX_W-1:0]               ptr_reg;
    logic [IDX_W-1:0]               ptr_next;

    logic [ADDR_BITS-1:0]           dst_reg;
    logic [ADDR_BITS-1:0]           src_reg;
    logic [mlpl_pkg::PORT_BITS-1:0] sport_reg;
    logic [ENTRIES-1:0]             dst_hit_reg;
    logic [ENTRIES-1:0]             src_hit_reg;

    logic [mlpl_pkg::PORT_BITS-1:0] out_mask_reg;
    logic [mlpl_pkg::PORT_BITS-1:0] out_mask_next;
    logic                           out_hit_reg;
    logic                           learned;

    assign learned  = |src_hit_reg;
    assign ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;

    // highest matching index wins
    always_comb begin
        out_mask_next = miss_port_mask;
        for (int i = 0; i < ENTRIES; i++) begin
            if (dst_hit_reg[i]) begin
                out_mask_next = pmask_reg[i];
            end
        end
    end

    // captured item and match vectors
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dst_reg   <= s_dest_address;
            src_reg   <= s_source_address;
            sport_reg <= s_source_port_mask;
        end
        if (cmd.match) begin
            for (int i = 0; i < ENTRIES; i++) begin
                dst_hit_reg[i] <= (addr_reg[i] == dst_reg);
                src_hit_reg[i] <= (addr_reg[i] == src_reg);
            end
        end
        if (cmd.commit) begin
            out_mask_reg <= out_mask_next;
            out_hit_reg  <= |dst_hit_reg;
        end
    end

    // table and replacement pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                addr_reg[i]  <= '0;
                pmask_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end else begin
            if (cmd.clear_ptr) begin
                ptr_reg <= '0;
            end
            if (cmd.commit) begin
                if (learned) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (src_hit_reg[i]) begin
                            pmask_reg[i] <= sport_reg;
                        end
                    end
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ptr_reg == IDX_W'(i)) begin
                            addr_reg[i]  <= src_reg;
                            pmask_reg[i] <= sport_reg;
                        end
                    end
                    ptr_reg <= ptr_next;
                end
            end
        end
    end

    assign m_out_port_mask = out_mask_reg;
    assign m_hit           = out_hit_reg;

endmodule : mlpl_dp
`default_nettype wire

/* rtl/core/mac_learning_port_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mac_learning_port_lookup
// Fully associative MAC learning table with destination port lookup.
// ----------------------------------------------------------------------------
// a lookup item goes through capture, compare and commit; its result is registered
//   at the commit, which waits while the result slot is full, and the input takes no
//   new item until then; an item without a request is taken every cycle and gives no result
// the compare cycle and the commit cycle share the table registers
// reset: table cleared to zero, pointer 0, miss mask 0x55, no result pending
module mac_learning_port_lookup #(
    parameter int unsigned ENTRIES   = mlpl_pkg::DEF_ENTRIES,
    parameter int unsigned ADDR_BITS = mlpl_pkg::DEF_ADDR_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // apb configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mlpl_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [mlpl_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [mlpl_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    // input items
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ADDR_BITS-1:0]               s_dest_address,
    input  wire logic [ADDR_BITS-1:0]               s_source_address,
    input  wire logic [mlpl_pkg::PORT_BITS-1:0]     s_source_port_mask,
    input  wire logic                               s_lookup_request,
    input  wire logic                               s_clear_pointer,
    // result items
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [mlpl_pkg::PORT_BITS-1:0]     m_out_port_mask,
    output logic                                    m_hit,
    output logic                                    m_miss,
    output logic                                    m_done_res
);

    mlpl_pkg::dp_cmd_t              cmd;
    logic [mlpl_pkg::PORT_BITS-1:0] miss_mask_reg;
    logic                           cfg_wr;
    logic                           sel_miss_mask;

    // register index is the word address
    assign sel_miss_mask = (paddr[2] == mlpl_pkg::REG_MISS_PORT_MASK);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_mask_reg <= mlpl_pkg::MISS_MASK_RESET;
        end else if (cfg_wr && sel_miss_mask) begin
            miss_mask_reg <= pwdata[mlpl_pkg::PORT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_miss_mask) begin
            prdata[mlpl_pkg::PORT_BITS-1:0] = miss_mask_reg;
        end
    end

    mlpl_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_lookup_request (s_lookup_request),
        .s_clear_pointer  (s_clear_pointer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cmd              (cmd)
    );

    mlpl_dp #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_dest_address     (s_dest_address),
        .s_source_address   (s_source_address),
        .s_source_port_mask (s_source_port_mask),
        .miss_port_mask     (miss_mask_reg),
        .m_out_port_mask    (m_out_port_mask),
        .m_hit              (m_hit)
    );

    assign m_miss     = !m_hit;
    assign m_done_res = 1'b1;

    // a lookup item keeps the input closed while it is in work
    a_busy_after_lookup : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_lookup_request |=> !s_ready)
        else $error("input open right after a lookup item");

    // an item without a request never produces a result or blocks
    a_no_request_passes : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_lookup_request && !m_valid |=> s_ready && !m_valid)
        else $error("item without request produced a result or stalled");

    // a new result only appears in the cycle after the controller commits
    a_result_from_commit : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

endmodule : mac_learning_port_lookup
`default_nettype wire

/* sim/mac_lookup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_lookup_checker
// Watches the configuration port and both item channels of the MAC learning
// lookup, keeps its own copy of the table, forwards and learns on every
// accepted item with a lookup request, and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module mac_lookup_checker #(
    parameter int unsigned ENTRY_COUNT = mlpl_pkg::DEF_ENTRIES,
    parameter int unsigned MAC_BITS    = mlpl_pkg::DEF_ADDR_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic                               pready,
    input  wire logic [mlpl_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [mlpl_pkg::APB_DATA_BITS-1:0] pwdata,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire logic [MAC_BITS-1:0]                s_dest_address,
    input  wire logic [MAC_BITS-1:0]                s_source_address,
    input  wire logic [mlpl_pkg::PORT_BITS-1:0]     s_source_port_mask,
    input  wire logic                               s_lookup_request,
    input  wire logic                               s_clear_pointer,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic [mlpl_pkg::PORT_BITS-1:0]     m_out_port_mask,
    input  wire logic                               m_hit,
    input  wire logic                               m_miss,
    input  wire logic                               m_done_res,
    output int unsigned                             mismatches,
    output int unsigned                             pending
);

    typedef logic [MAC_BITS-1:0]            mac_t;
    typedef logic [mlpl_pkg::PORT_BITS-1:0] mask_t;

    typedef struct packed {
        mask_t port_mask;
        logic  hit;
        logic  miss;
        logic  done;
    } forward_result_t;

    localparam logic [mlpl_pkg::APB_ADDR_BITS-1:0] MISS_MASK_ADDR =
        {mlpl_pkg::REG_MISS_PORT_MASK, 2'b00};
    localparam int unsigned PRINT_CAP = 64;

    mac_t            station_mac [ENTRY_COUNT];
    mask_t           station_port[ENTRY_COUNT];
    int unsigned     replace_ptr;
    mask_t           miss_mask;
    forward_result_t forward_q[$];
    int unsigned     fault_total = 0;
    int unsigned     queued      = 0;

    assign mismatches = fault_total;
    assign pending    = queued;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fault_total < PRINT_CAP)
            $display("%0d ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fault_total = fault_total + 1;
    endtask

    // lookup sees the table as it stood before this item, then learning applies
    task automatic forward_and_learn(input mac_t dst, input mac_t src, input mask_t sport,
                                     input logic req, input logic clr);
        forward_result_t res;
        logic            learned;
        int              k;
        if (clr)
            replace_ptr = 0;
        if (req) begin
            res.port_mask = miss_mask;
            res.hit       = 1'b0;
            learned       = 1'b0;
            for (k = 0; k < ENTRY_COUNT; k++) begin
                if (station_mac[k] == dst) begin
                    res.port_mask = station_port[k];
                    res.hit       = 1'b1;
                end
                if (station_mac[k] == src) begin
                    station_port[k] = sport;
                    learned         = 1'b1;
                end
            end
            if (!learned) begin
                station_mac[replace_ptr]  = src;
                station_port[replace_ptr] = sport;
                replace_ptr = (replace_ptr + 1) % ENTRY_COUNT;
            end
            res.miss = !res.hit;
            res.done = 1'b1;
            forward_q.push_back(res);
        end
    endtask

    task automatic check_result();
        forward_result_t want;
        if (forward_q.size() == 0) begin
            report_mismatch("result item with nothing expected", 64'(m_out_port_mask),
                            64'(0));
        end else begin
            want = forward_q.pop_front();
            if (m_out_port_mask !== want.port_mask)
                report_mismatch("out_port_mask", 64'(m_out_port_mask), 64'(want.port_mask));
            if (m_hit !== want.hit)
                report_mismatch("hit", 64'(m_hit), 64'(want.hit));
            if (m_miss !== want.miss)
                report_mismatch("miss", 64'(m_miss), 64'(want.miss));
            if (m_done_res !== want.done)
                report_mismatch("done_res", 64'(m_done_res), 64'(want.done));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (station_mac[k]) begin
                station_mac[k]  = '0;
                station_port[k] = '0;
            end
            replace_ptr = 0;
            miss_mask   = mlpl_pkg::MISS_MASK_RESET;
            forward_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == MISS_MASK_ADDR)
                miss_mask = pwdata[mlpl_pkg::PORT_BITS-1:0];
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                forward_and_learn(s_dest_address, s_source_address, s_source_port_mask,
                                  s_lookup_request, s_clear_pointer);
        end
        queued = forward_q.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the MAC learning lookup with directed and random items over APB
// settings of the miss mask, with random stalls on both channels; the
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MAC_BITS        = mlpl_pkg::DEF_ADDR_BITS;
    localparam int unsigned POOL_SIZE       = 24;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam logic [mlpl_pkg::APB_ADDR_BITS-1:0] MISS_MASK_ADDR =
        {mlpl_pkg::REG_MISS_PORT_MASK, 2'b00};

    typedef logic [MAC_BITS-1:0]            mac_t;
    typedef logic [mlpl_pkg::PORT_BITS-1:0] mask_t;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [mlpl_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [mlpl_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [mlpl_pkg::APB_DATA_BITS-1:0] prdata;
    logic pready;
    logic s_valid, s_ready;
    mac_t s_dest_address, s_source_address;
    mask_t s_source_port_mask;
    logic s_lookup_request, s_clear_pointer;
    logic m_valid, m_ready;
    mask_t m_out_port_mask;
    logic m_hit, m_miss, m_done_res;

    int unsigned mismatch_total;
    int unsigned pending_results;

    logic calm         = 1'b0;
    logic hold_results = 1'b0;
    mac_t mac_pool[POOL_SIZE];

    mac_learning_port_lookup uut (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_dest_address, .s_source_address, .s_source_port_mask,
        .s_lookup_request, .s_clear_pointer,
        .m_valid, .m_ready, .m_out_port_mask, .m_hit, .m_miss, .m_done_res
    );

    mac_lookup_checker u_checker (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .s_valid, .s_ready, .s_dest_address, .s_source_address, .s_source_port_mask,
        .s_lookup_request, .s_clear_pointer,
        .m_valid, .m_ready, .m_out_port_mask, .m_hit, .m_miss, .m_done_res,
        .mismatches(mismatch_total), .pending(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic mac_t any_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MAC_BITS-1:0];
    endfunction

    // mostly addresses the table can hold, some noise
    function automatic mac_t pick_mac();
        if ($urandom_range(0, 4) == 0)
            return any_mac();
        return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_item(input mac_t dst, input mac_t src, input mask_t sport,
                             input logic req, input logic clr);
        s_valid            <= 1'b1;
        s_dest_address     <= dst;
        s_source_address   <= src;
        s_source_port_mask <= sport;
        s_lookup_request   <= req;
        s_clear_pointer    <= clr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic rest_input(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results(input int unsigned extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_miss_mask(input mask_t value);
        logic [mlpl_pkg::APB_DATA_BITS-1:0] word;
        word = $urandom;
        word[mlpl_pkg::PORT_BITS-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MISS_MASK_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned done_items;
        int unsigned gap_odds;
        int unsigned k;
        logic req, clr;
        done_items = 0;
        gap_odds   = 0;
        k          = 0;
        while (done_items < count) begin
            if (k % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 4;
                    default: gap_odds = 16;
                endcase
                // let the pool drift so learning keeps replacing entries
                mac_pool[$urandom_range(2, POOL_SIZE - 1)] = any_mac();
            end
            k   = k + 1;
            req = $urandom_range(0, 99) < 85;
            clr = $urandom_range(0, 99) < 6;
            send_item(pick_mac(), pick_mac(), 8'($urandom_range(0, 255)), req, clr);
            done_items = done_items + 1;
            if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                rest_input($urandom_range(1, 19));
        end
    endtask

    // result side: random stall bursts, long ready runs, one long hold-off
    initial begin : result_sink
        int unsigned run_left;
        run_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                hold_results = 1'b0;
            end else if (calm || run_left > 0) begin
                m_ready <= 1'b1;
                if (run_left > 0)
                    run_left = run_left - 1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(posedge aclk);
                run_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 60);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
                if (quiet >= WATCHDOG_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        mac_t all_ones;
        mac_t mac_b;
        mac_t mac_c;
        all_ones = '1;
        aresetn            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        s_valid            <= 1'b0;
        s_dest_address     <= '0;
        s_source_address   <= '0;
        s_source_port_mask <= '0;
        s_lookup_request   <= 1'b0;
        s_clear_pointer    <= 1'b0;
        foreach (mac_pool[k])
            mac_pool[k] = any_mac();
        mac_pool[0] = '0;
        mac_pool[1] = all_ones;
        mac_b = any_mac();
        mac_c = 48'h0123_4567_89ab;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero address hits every reset entry: highest wins, all learn
        send_item('0, '0, 8'hff, 1'b1, 1'b0);
        send_item('0, all_ones, 8'h01, 1'b1, 1'b0);
        send_item(all_ones, mac_b, 8'h80, 1'b1, 1'b0);
        send_item(mac_c, all_ones, 8'h02, 1'b1, 1'b0);
        // clear with no request gives nothing
        send_item(any_mac(), any_mac(), 8'h5a, 1'b0, 1'b1);
        // clear together with a request: learning starts again at entry 0
        send_item(mac_b, mac_c, 8'h04, 1'b1, 1'b1);
        send_item(all_ones, all_ones, 8'h00, 1'b1, 1'b0);
        send_item(any_mac(), any_mac(), 8'h33, 1'b0, 1'b0);
        send_item('0, mac_c, 8'hff, 1'b1, 1'b0);
        send_item(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 8'haa, 1'b1, 1'b0);
        send_item(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 8'h55, 1'b1, 1'b0);
        send_item(mac_c, '0, 8'h10, 1'b1, 1'b0);
        send_item(48'h5555_5555_5555, all_ones, 8'h20, 1'b1, 1'b1);
        send_item(all_ones, any_mac(), 8'h00, 1'b1, 1'b0);

        drain_results(SETTLE_CYCLES);
        write_miss_mask(8'hff);
        run_random(150);
        hold_results = 1'b1;
        run_random(250);

        drain_results(SETTLE_CYCLES);
        write_miss_mask(8'h00);
        run_random(200);
        drain_results(0);
        run_random(200);

        drain_results(SETTLE_CYCLES);
        write_miss_mask(8'($urandom_range(1, 254)));
        run_random(400);

        drain_results(SETTLE_CYCLES);
        write_miss_mask(8'($urandom_range(0, 255)));
        calm = 1'b1;
        run_random(450);

        drain_results(SETTLE_CYCLES);
        if (mismatch_total == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
